>>> hdl/qife_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qife_pkg
// Shared widths, constants, result records and sample conversion for the
// quadrature instantaneous frequency estimator.
// ---------------------------------------------------------------------------
package qife_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int CORE_W       = 16;
  localparam int DIFF_W       = CORE_W + 1;
  localparam int SCALE_W      = 24;
  localparam int MAG_W        = 32;
  localparam int ACC_MAG_W    = MAG_W + 2;
  localparam int NUM_W        = 2 * CORE_W + 3;
  localparam int NMAG_W       = 2 * CORE_W + 1;
  localparam int PROD_W       = NMAG_W + SCALE_W;
  localparam int FREQ_W       = 32;
  localparam int ROOT_W       = MAG_W / 2;

  localparam int PROD_CYC   = CORE_W / 2;
  localparam int MUL_CYC    = SCALE_W / 2;
  localparam int DIV_CYC    = FREQ_W / 2;
  localparam int SQRT_CYC   = ROOT_W;
  localparam int PROD_CNT_W = $clog2(PROD_CYC);
  localparam int MUL_CNT_W  = $clog2(MUL_CYC);
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);
  localparam int SQRT_CNT_W = $clog2(SQRT_CYC);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(898405);
  localparam int                 MAG_OFFSET  = 1024;
  localparam logic [FREQ_W-1:0]  FREQ_MAX    = {1'b0, {(FREQ_W-1){1'b1}}};
  localparam logic [FREQ_W-1:0]  FREQ_MIN    = {1'b1, {(FREQ_W-1){1'b0}}};

  typedef struct packed {
    logic [MAG_W-1:0]  mag2;
    logic              neg;
    logic [NMAG_W-1:0] nabs;
  } prod_res_t;

  typedef struct packed {
    logic [FREQ_W-1:0] quot;
    logic              ovf;
  } div_res_t;

  function automatic logic signed [CORE_W-1:0] to_core(input logic [SAMPLE_WIDTH-1:0] raw);
    logic [SAMPLE_WIDTH+CORE_W-1:0] ext;
    ext = {raw, {CORE_W{1'b0}}};
    return ext[SAMPLE_WIDTH+CORE_W-1 -: CORE_W];
  endfunction

endpackage
`default_nettype wire

>>> hdl/qife_prod.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qife_prod
// Serial shift-add products, two multiplier bits per cycle: squared
// magnitude of the middle sample and the cross-difference numerator.
// ---------------------------------------------------------------------------
module qife_prod (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  input  wire logic signed [qife_pkg::CORE_W-1:0] x1_i,
  input  wire logic signed [qife_pkg::CORE_W-1:0] y1_i,
  input  wire logic signed [qife_pkg::DIFF_W-1:0] dx_i,
  input  wire logic signed [qife_pkg::DIFF_W-1:0] dy_i,
  output logic                                done_o,
  output qife_pkg::prod_res_t                 res_o
);

  logic                                      busy_q, busy_d;
  logic                                      done_q, done_d;
  logic [qife_pkg::PROD_CNT_W-1:0]           cnt_q, cnt_d;
  logic [qife_pkg::CORE_W-1:0]               bx_q, bx_d, by_q, by_d;
  logic signed [qife_pkg::ACC_MAG_W-1:0]     mx_q, mx_d, my_q, my_d;
  logic signed [qife_pkg::NUM_W-1:0]         mdx_q, mdx_d, mdy_q, mdy_d;
  logic signed [qife_pkg::ACC_MAG_W-1:0]     accm_q, accm_d, wm;
  logic signed [qife_pkg::NUM_W-1:0]         accn_q, accn_d, wn, nneg;
  logic                                      last_cyc;

  assign last_cyc = (cnt_q == qife_pkg::PROD_CNT_W'(qife_pkg::PROD_CYC - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && last_cyc;
    bx_d   = bx_q;
    by_d   = by_q;
    mx_d   = mx_q;
    my_d   = my_q;
    mdx_d  = mdx_q;
    mdy_d  = mdy_q;
    accm_d = accm_q;
    accn_d = accn_q;
    wm     = '0;
    wn     = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bx_d   = x1_i;
      by_d   = y1_i;
      mx_d   = qife_pkg::ACC_MAG_W'(x1_i);
      my_d   = qife_pkg::ACC_MAG_W'(y1_i);
      mdx_d  = qife_pkg::NUM_W'(dx_i);
      mdy_d  = qife_pkg::NUM_W'(dy_i);
      accm_d = qife_pkg::ACC_MAG_W'(qife_pkg::MAG_OFFSET);
      accn_d = '0;
    end else if (busy_q) begin
      for (int k = 0; k < 2; k++) begin
        wm = (bx_d[0] ? mx_d : '0) + (by_d[0] ? my_d : '0);
        wn = (bx_d[0] ? mdy_d : '0) - (by_d[0] ? mdx_d : '0);
        if (last_cyc && (k == 1)) begin
          accm_d = accm_d - wm;
          accn_d = accn_d - wn;
        end else begin
          accm_d = accm_d + wm;
          accn_d = accn_d + wn;
        end
        mx_d  = mx_d <<< 1;
        my_d  = my_d <<< 1;
        mdx_d = mdx_d <<< 1;
        mdy_d = mdy_d <<< 1;
        bx_d  = bx_d >> 1;
        by_d  = by_d >> 1;
      end
      cnt_d = cnt_q + 1'b1;
      if (last_cyc) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bx_q   <= bx_d;
    by_q   <= by_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    mdx_q  <= mdx_d;
    mdy_q  <= mdy_d;
    accm_q <= accm_d;
    accn_q <= accn_d;
  end

  assign nneg       = -accn_q;
  assign res_o.mag2 = accm_q[qife_pkg::MAG_W-1:0];
  assign res_o.neg  = accn_q[qife_pkg::NUM_W-1];
  assign res_o.nabs = accn_q[qife_pkg::NUM_W-1] ? nneg[qife_pkg::NMAG_W-1:0]
                                                : accn_q[qife_pkg::NMAG_W-1:0];
  assign done_o     = done_q;

endmodule
`default_nettype wire

>>> hdl/qife_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qife_mul
// Serial unsigned multiply of the scale factor by the numerator magnitude,
// two scale bits per cycle, right-shifting product register.
// ---------------------------------------------------------------------------
module qife_mul (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire logic [qife_pkg::SCALE_W-1:0]  scale_i,
  input  wire logic [qife_pkg::NMAG_W-1:0]   nabs_i,
  output logic                               done_o,
  output logic [qife_pkg::PROD_W-1:0]        prod_o
);

  localparam int PW = qife_pkg::NMAG_W + 1 + qife_pkg::SCALE_W;
  localparam int SW = qife_pkg::NMAG_W + 1;

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [qife_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]                  p_q, p_d;
  logic [qife_pkg::NMAG_W-1:0]    mc_q, mc_d;
  logic [SW-1:0]                  s;
  logic                           last_cyc;

  assign last_cyc = (cnt_q == qife_pkg::MUL_CNT_W'(qife_pkg::MUL_CYC - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && last_cyc;
    p_d    = p_q;
    mc_d   = mc_q;
    s      = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      p_d    = {{SW{1'b0}}, scale_i};
      mc_d   = nabs_i;
    end else if (busy_q) begin
      for (int k = 0; k < 2; k++) begin
        s   = p_d[PW-1:qife_pkg::SCALE_W] + (p_d[0] ? {1'b0, mc_q} : {SW{1'b0}});
        p_d = {1'b0, s, p_d[qife_pkg::SCALE_W-1:1]};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_cyc) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    mc_q <= mc_d;
  end

  assign prod_o = p_q[qife_pkg::PROD_W-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

>>> hdl/qife_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qife_div
// Restoring divide of the scaled numerator by the squared magnitude, two
// quotient bits per cycle, with an up-front overflow check.
// ---------------------------------------------------------------------------
module qife_div (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire logic [qife_pkg::PROD_W-1:0]  dividend_i,
  input  wire logic [qife_pkg::MAG_W-1:0]   divisor_i,
  output logic                              done_o,
  output qife_pkg::div_res_t                res_o
);

  localparam int RW = qife_pkg::MAG_W + 1;
  localparam int QW = qife_pkg::FREQ_W;

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [qife_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RW-1:0]                  r_q, r_d, t;
  logic [QW-1:0]                  z_q, z_d;
  logic [qife_pkg::MAG_W-1:0]     d_q, d_d;
  logic                           ovf_q, ovf_d;
  logic                           qb;
  logic                           last_cyc;

  assign last_cyc = (cnt_q == qife_pkg::DIV_CNT_W'(qife_pkg::DIV_CYC - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && last_cyc;
    r_d    = r_q;
    z_d    = z_q;
    d_d    = d_q;
    ovf_d  = ovf_q;
    t      = '0;
    qb     = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      d_d    = divisor_i;
      ovf_d  = (RW'(dividend_i[qife_pkg::PROD_W-1:QW]) >= RW'(divisor_i));
      r_d    = RW'(dividend_i[qife_pkg::PROD_W-1:QW]);
      z_d    = dividend_i[QW-1:0];
    end else if (busy_q) begin
      for (int k = 0; k < 2; k++) begin
        t  = {r_d[RW-2:0], z_d[QW-1]};
        qb = (t >= {1'b0, d_q});
        if (qb) begin
          t = t - {1'b0, d_q};
        end
        r_d = t;
        z_d = {z_d[QW-2:0], qb};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_cyc) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    z_q   <= z_d;
    d_q   <= d_d;
    ovf_q <= ovf_d;
  end

  assign res_o.quot = z_q;
  assign res_o.ovf  = ovf_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

>>> hdl/qife_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qife_isqrt
// Digit-by-digit floor square root of the squared magnitude, one root bit
// per cycle.
// ---------------------------------------------------------------------------
module qife_isqrt (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire logic [qife_pkg::MAG_W-1:0]  value_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [qife_pkg::ROOT_W-1:0]      root_o
);

  localparam int REM_W = qife_pkg::ROOT_W + 1;
  localparam int T_W   = qife_pkg::ROOT_W + 3;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [qife_pkg::SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic [qife_pkg::MAG_W-1:0]      v_q, v_d;
  logic [REM_W-1:0]                rem_q, rem_d;
  logic [qife_pkg::ROOT_W-1:0]     root_q, root_d;
  logic [T_W-1:0]                  t, trial;
  logic                            last_cyc;

  assign last_cyc = (cnt_q == qife_pkg::SQRT_CNT_W'(qife_pkg::SQRT_CYC - 1));
  assign t        = {rem_q, v_q[qife_pkg::MAG_W-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && last_cyc;
    v_d    = v_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      v_d    = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      v_d = v_q << 2;
      if (t >= trial) begin
        rem_d  = REM_W'(t - trial);
        root_d = {root_q[qife_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = t[REM_W-1:0];
        root_d = {root_q[qife_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (last_cyc) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> hdl/quadrature_inst_freq_estimator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quadrature_inst_freq_estimator_top
// Derivative FM discriminator: instantaneous frequency, squared magnitude
// and magnitude from successive I/Q sample requests.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  x_sample_i, y_sample_i
//   out      source     out_valid_o / out_stall_i
//                                   inst_freq_o, magnitude_squared_o, magnitude_o
//   cfg      sink       cfg_we_i                 cfg_wdata_i (scale factor)
//
// Each request passes through a load, 2-bit shift-add products, a handoff,
// the scale multiply, a handoff and the 2-bit restoring divide, then finishes
// and loads the output register. The square root runs beside the multiply
// and divide. A new request is accepted only once the last result is loaded.
// Reset clears the delay line and sets the scale factor to 44100 Hz.
// A stalled result holds in the output register; the next request is
// accepted meanwhile and waits only at the final load.
// ---------------------------------------------------------------------------
module quadrature_inst_freq_estimator_top (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [qife_pkg::SAMPLE_WIDTH-1:0] x_sample_i,
  input  wire logic signed [qife_pkg::SAMPLE_WIDTH-1:0] y_sample_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic signed [qife_pkg::FREQ_W-1:0]      inst_freq_o,
  output logic [qife_pkg::MAG_W-1:0]              magnitude_squared_o,
  output logic [qife_pkg::ROOT_W-1:0]             magnitude_o,
  input  wire                                     cfg_we_i,
  input  wire logic [qife_pkg::SCALE_W-1:0]       cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                           state_q, state_d;
  logic [qife_pkg::SCALE_W-1:0]         scale_q;
  logic signed [qife_pkg::CORE_W-1:0]   x1_q, x2_q, y1_q, y2_q, x0, y0;
  logic signed [qife_pkg::DIFF_W-1:0]   dx, dy;
  logic                                 in_accept, out_load;
  logic                                 out_valid_q, out_valid_d;
  logic signed [qife_pkg::FREQ_W-1:0]   freq_q, freq_d;
  logic [qife_pkg::MAG_W-1:0]           mag2_q;
  logic [qife_pkg::ROOT_W-1:0]          mag_q;

  logic                                 prod_done, mul_done, div_done;
  logic                                 sqrt_done, sqrt_busy;
  qife_pkg::prod_res_t                  prod_res;
  qife_pkg::div_res_t                   div_res;
  logic [qife_pkg::PROD_W-1:0]          scaled;
  logic [qife_pkg::ROOT_W-1:0]          root;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign x0 = qife_pkg::to_core(x_sample_i);
  assign y0 = qife_pkg::to_core(y_sample_i);
  assign dx = qife_pkg::DIFF_W'(x0) - qife_pkg::DIFF_W'(x2_q);
  assign dy = qife_pkg::DIFF_W'(y0) - qife_pkg::DIFF_W'(y2_q);

  qife_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .x1_i    (x1_q),
    .y1_i    (y1_q),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (prod_done),
    .res_o   (prod_res)
  );

  qife_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_done),
    .scale_i (scale_q),
    .nabs_i  (prod_res.nabs),
    .done_o  (mul_done),
    .prod_o  (scaled)
  );

  qife_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_done),
    .dividend_i (scaled),
    .divisor_i  (prod_res.mag2),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  qife_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_done),
    .value_i (prod_res.mag2),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_accept) state_d = ST_RUN;
      ST_RUN:  if (div_done)  state_d = ST_FIN;
      ST_FIN:  if (out_load)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (prod_res.neg) begin
      if (div_res.ovf || (div_res.quot > qife_pkg::FREQ_MIN)) begin
        freq_d = qife_pkg::FREQ_MIN;
      end else begin
        freq_d = -div_res.quot;
      end
    end else begin
      if (div_res.ovf || div_res.quot[qife_pkg::FREQ_W-1]) begin
        freq_d = qife_pkg::FREQ_MAX;
      end else begin
        freq_d = div_res.quot;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      scale_q     <= qife_pkg::SCALE_RESET;
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        x2_q <= x1_q;
        x1_q <= x0;
        y2_q <= y1_q;
        y1_q <= y0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      freq_q <= freq_d;
      mag2_q <= prod_res.mag2;
      mag_q  <= root;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign inst_freq_o         = freq_q;
  assign magnitude_squared_o = mag2_q;
  assign magnitude_o         = mag_q;

  a_sqrt_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> !sqrt_busy && !sqrt_done)
    else $error("square root still running at divide completion");

  a_prod_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_done |-> state_q == ST_RUN)
    else $error("product completion outside a running request");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result loaded without a finished request");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((33'(magnitude_o) * 33'(magnitude_o) <= 33'(magnitude_squared_o)) &&
                     ((33'(magnitude_o) + 33'd1) * (33'(magnitude_o) + 33'd1) >
                      33'(magnitude_squared_o))))
    else $error("magnitude is not the floor root of magnitude squared");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature instantaneous frequency estimator.
// A directed table covers reset state, sample extremes, saturation of the
// quotient in both directions and scale factor extremes. Random I/Q requests
// follow in four idle/stall phases, each under its own scale factor. Every
// result is checked field by field against a table row or discriminator model.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int SW        = qife_pkg::SAMPLE_WIDTH;
  localparam int RAND_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 800000;
  localparam int TAIL_CYCLES = 60;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    logic signed [qife_pkg::FREQ_W-1:0] freq;
    logic [qife_pkg::MAG_W-1:0]         mag2;
    logic [qife_pkg::ROOT_W-1:0]        mag;
  } disc_result_t;

  typedef struct {
    bit                           wr_scale;
    logic [qife_pkg::SCALE_W-1:0] scale;
    sample_t                      xs;
    sample_t                      ys;
    bit                           typed;
    disc_result_t                 res;
  } stim_row_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall_o;
  sample_t                            x_sample = '0;
  sample_t                            y_sample = '0;
  logic                               out_valid_o;
  logic                               out_stall = 1'b0;
  logic signed [qife_pkg::FREQ_W-1:0] inst_freq_o;
  logic [qife_pkg::MAG_W-1:0]         magnitude_squared_o;
  logic [qife_pkg::ROOT_W-1:0]        magnitude_o;
  logic                               cfg_we = 1'b0;
  logic [qife_pkg::SCALE_W-1:0]       cfg_wdata = '0;

  logic [qife_pkg::SCALE_W-1:0]       scale_q = qife_pkg::SCALE_RESET;
  logic signed [qife_pkg::CORE_W-1:0] x_d1 = '0, x_d2 = '0, y_d1 = '0, y_d2 = '0;

  disc_result_t freq_expect_q[$];
  disc_result_t got_exp;
  stim_row_t    dir_rows[$];
  int           err_count = 0;
  int           result_idx = 0;
  int           cycle_count = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;

  quadrature_inst_freq_estimator_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .x_sample_i          (x_sample),
    .y_sample_i          (y_sample),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .inst_freq_o         (inst_freq_o),
    .magnitude_squared_o (magnitude_squared_o),
    .magnitude_o         (magnitude_o),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  function automatic logic signed [qife_pkg::CORE_W-1:0] core_sample(input sample_t raw);
    logic [63:0] w;
    w = 64'(raw) & ((64'd1 << SW) - 64'd1);
    w = (SW >= qife_pkg::CORE_W) ? (w >> (SW - qife_pkg::CORE_W))
                                 : (w << (qife_pkg::CORE_W - SW));
    return w[qife_pkg::CORE_W-1:0];
  endfunction

  function automatic logic [qife_pkg::ROOT_W-1:0] floor_root(
      input logic [qife_pkg::MAG_W-1:0] v);
    logic [qife_pkg::ROOT_W-1:0] r;
    logic [qife_pkg::ROOT_W-1:0] trial;
    r = '0;
    for (int b = qife_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = r | (qife_pkg::ROOT_W'(1) << b);
      if (longint'(trial) * longint'(trial) <= longint'(v))
        r = trial;
    end
    return r;
  endfunction

  function automatic disc_result_t advance_discriminator(input sample_t xr, input sample_t yr);
    logic signed [qife_pkg::CORE_W-1:0] x0, y0;
    longint x1, y1, x2, y2, mag2, num, quo;
    disc_result_t r;
    x0 = core_sample(xr);
    y0 = core_sample(yr);
    x1 = x_d1;
    y1 = y_d1;
    x2 = x_d2;
    y2 = y_d2;
    mag2 = x1 * x1 + y1 * y1 + qife_pkg::MAG_OFFSET;
    num = x1 * (longint'(y0) - y2) - y1 * (longint'(x0) - x2);
    quo = (longint'(scale_q) * num) / mag2;
    if (quo > 64'sh7FFF_FFFF)
      quo = 64'sh7FFF_FFFF;
    if (quo < -64'sh8000_0000)
      quo = -64'sh8000_0000;
    r.freq = quo[qife_pkg::FREQ_W-1:0];
    r.mag2 = mag2[qife_pkg::MAG_W-1:0];
    r.mag  = floor_root(mag2[qife_pkg::MAG_W-1:0]);
    x_d2 = x_d1;
    x_d1 = x0;
    y_d2 = y_d1;
    y_d1 = y0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    $display("MISMATCH %s at result %0d: expected %0d, got %0d",
             what, result_idx, exp_v, got_v);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (freq_expect_q.size() == 0) begin
        report_mismatch("result with no request outstanding", 0, 0);
      end else begin
        got_exp = freq_expect_q.pop_front();
        if (inst_freq_o !== got_exp.freq)
          report_mismatch("inst_freq", longint'(got_exp.freq), longint'(inst_freq_o));
        if (magnitude_squared_o !== got_exp.mag2)
          report_mismatch("magnitude_squared", longint'(got_exp.mag2),
                          longint'(magnitude_squared_o));
        if (magnitude_o !== got_exp.mag)
          report_mismatch("magnitude", longint'(got_exp.mag), longint'(magnitude_o));
      end
      result_idx++;
    end
  end

  // drop valid and hold until every outstanding result is back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (freq_expect_q.size() != 0);
  endtask

  task automatic write_scale(input logic [qife_pkg::SCALE_W-1:0] v);
    pause_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    scale_q = v;
  endtask

  task automatic send_request(input sample_t xs, input sample_t ys, input bit typed,
                              input disc_result_t typed_res);
    disc_result_t pred;
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    x_sample <= xs;
    y_sample <= ys;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!(in_valid && !in_stall_o));
    pred = advance_discriminator(xs, ys);
    freq_expect_q.push_back(typed ? typed_res : pred);
  endtask

  function automatic sample_t rand_sample();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return sample_t'({$urandom, $urandom});
      5, 6: begin
        v = $urandom_range(128);
        return sample_t'(v - 64);
      end
      7: begin
        case ($urandom_range(4))
          0: return {1'b0, {(SW-1){1'b1}}};
          1: return {1'b1, {(SW-1){1'b0}}};
          2: return '0;
          3: return '1;
          default: return sample_t'(1);
        endcase
      end
      default: begin
        v = $urandom_range(4096);
        return sample_t'(v - 2048);
      end
    endcase
  endfunction

  task automatic add_scale(input logic [qife_pkg::SCALE_W-1:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.wr_scale = 1'b1;
    r.scale = v;
    dir_rows.push_back(r);
  endtask

  task automatic add_sample(input int xs, input int ys);
    stim_row_t r;
    r = '{default: '0};
    r.xs = sample_t'(xs);
    r.ys = sample_t'(ys);
    dir_rows.push_back(r);
  endtask

  task automatic add_checked(input int xs, input int ys,
                             input logic signed [qife_pkg::FREQ_W-1:0] f,
                             input logic [qife_pkg::MAG_W-1:0] m2,
                             input logic [qife_pkg::ROOT_W-1:0] m);
    stim_row_t r;
    r = '{default: '0};
    r.xs = sample_t'(xs);
    r.ys = sample_t'(ys);
    r.typed = 1'b1;
    r.res.freq = f;
    r.res.mag2 = m2;
    r.res.mag = m;
    dir_rows.push_back(r);
  endtask

  initial begin
    stim_row_t    row;
    disc_result_t none;
    int           per_phase;
    none = '0;

    add_checked(32767, 0, 0, 32'd1024, 16'd32);
    add_checked(0, 0, 0, 32'd1073677313, 16'd32767);
    add_checked(0, 0, 0, 32'd1024, 16'd32);
    add_checked(-32768, -32768, 0, 32'd1024, 16'd32);
    add_checked(-32768, -32768, 0, 32'd2147484672, 16'd46340);
    add_checked(32767, 32767, 0, 32'd2147484672, 16'd46340);
    add_sample(-1, 1);
    add_sample(1, -1);
    add_scale(24'hFF_FFFF);
    add_sample(0, -32768);
    add_sample(32, 0);
    add_checked(0, 32767, qife_pkg::FREQ_MAX, 32'd2048, 16'd45);
    add_sample(32, 0);
    add_checked(0, -32768, qife_pkg::FREQ_MIN, 32'd2048, 16'd45);
    add_scale(24'd0);
    add_sample(12345, -23456);
    add_sample(-32768, 32767);
    add_sample(32767, -32768);
    add_scale(24'd1);
    add_sample(100, -200);
    add_sample(-300, 400);
    add_scale(qife_pkg::SCALE_RESET);
    add_sample(1, 1);
    add_sample(-1, -1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.wr_scale)
        write_scale(row.scale);
      else
        send_request(row.xs, row.ys, row.typed, row.res);
    end

    per_phase = RAND_ITEMS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_scale(qife_pkg::SCALE_RESET);
        1: write_scale(24'hFF_FFFF);
        2: write_scale(qife_pkg::SCALE_W'($urandom_range(1, 24'hFF_FFFF)));
        default: write_scale(qife_pkg::SCALE_W'($urandom_range(0, 255)));
      endcase
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        if (ph == 1 && n == per_phase / 2)
          pause_until_drained();
        send_request(rand_sample(), rand_sample(), 1'b0, none);
      end
    end

    pause_until_drained();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (freq_expect_q.size() != 0)
      report_mismatch("results missing at end", 0, freq_expect_q.size());
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
